// ===== design/assert_macros.svh =====
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// When pre holds, post must hold at the following clock edge.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/hpid_pkg.sv =====
// Shared types, register codes and reset values of the heater PID controller.
`timescale 1ns / 1ps

package hpid_pkg;

   localparam int TEMP_BITS_DEF  = 10;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DUTY_BITS      = 8;
   localparam int ESUM_BITS      = 16;

   localparam logic [DUTY_BITS-1:0] DUTY_MAX = 8'd255;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_PROP         = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_INTEGRAL     = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_DERIV        = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_PROP_STANDBY = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STANDBY_TARGET    = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INTEGRAL_LIMIT    = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_JUMP          = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_BAD_SAMPLES   = 4'd7;

   typedef struct packed {
      logic [15:0] gain_prop;
      logic [15:0] gain_integral;
      logic [15:0] gain_deriv;
      logic [15:0] gain_prop_standby;
      logic [9:0]  standby_target;
      logic [14:0] integral_limit;
      logic [9:0]  max_jump;
      logic [7:0]  max_bad_samples;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_prop:         16'd512,
      gain_integral:     16'd13,
      gain_deriv:        16'd1254,
      gain_prop_standby: 16'd512,
      standby_target:    10'd150,
      integral_limit:    15'd5100,
      max_jump:          10'd50,
      max_bad_samples:   8'd10
   };

   // Control that travels with each request down the pipeline.
   typedef struct packed {
      logic valid;
      logic standby;
      logic fault;
   } stage_ctl_type;

endpackage

// ===== design/hpid_update.sv =====
// Update stage: erratic-sample guard, fault latch, error sum and PID operands.
`timescale 1ns / 1ps

module hpid_update #(
   parameter int TEMP_BITS = hpid_pkg::TEMP_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [TEMP_BITS-1:0]              in_temp,
   input  logic [TEMP_BITS-1:0]              in_target,
   input  logic                              in_standby,
   input  hpid_pkg::cfg_type                 cfg,
   output hpid_pkg::stage_ctl_type           out_ctl,
   output logic signed [TEMP_BITS:0]         out_diff,
   output logic signed [TEMP_BITS:0]         out_dtemp,
   output logic signed [hpid_pkg::ESUM_BITS-1:0] out_esum,
   input  logic                              out_ready
);

   localparam int CW = (TEMP_BITS > 10) ? TEMP_BITS : 10;
   localparam int EW = hpid_pkg::ESUM_BITS;

   logic [TEMP_BITS-1:0]    prev_ff, prev_in;
   logic                    primed_ff;
   logic signed [EW-1:0]    esum_ff, esum_in;
   logic [7:0]              bad_ff, bad_in;
   logic                    fault_ff, fault_in;

   hpid_pkg::stage_ctl_type ctl_ff;
   logic signed [TEMP_BITS:0] diff_ff, dtemp_ff, diff_in, dtemp_in;
   logic signed [EW-1:0]    esum_out_ff;

   logic [TEMP_BITS-1:0]    prev_eff, jump, tgt_eff;
   logic                    erratic, fire;
   logic signed [EW:0]      sum, lim, clamped;

   assign in_ready = !ctl_ff.valid || out_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      // The first sample after reset is compared against itself.
      prev_eff = primed_ff ? prev_ff : in_temp;
      jump     = (in_temp > prev_eff) ? (in_temp - prev_eff) : (prev_eff - in_temp);
      erratic  = CW'(jump) > CW'(cfg.max_jump);
      prev_in  = erratic ? prev_eff : in_temp;

      if (erratic) begin
         bad_in = (bad_ff == 8'hFF) ? bad_ff : bad_ff + 8'd1;
      end else begin
         bad_in = 8'd0;
      end
      fault_in = erratic && (bad_in > cfg.max_bad_samples);

      tgt_eff  = in_standby ? TEMP_BITS'(cfg.standby_target) : in_target;
      diff_in  = $signed({1'b0, tgt_eff}) - $signed({1'b0, prev_in});
      dtemp_in = $signed({1'b0, prev_in}) - $signed({1'b0, prev_eff});

      sum = (EW+1)'(esum_ff) + (EW+1)'(diff_in);
      lim = $signed({2'b00, cfg.integral_limit});
      if (sum > lim) begin
         clamped = lim;
      end else if (sum < -lim) begin
         clamped = -lim;
      end else begin
         clamped = sum;
      end
      esum_in = in_standby ? esum_ff : EW'(clamped);
   end

   // Loop state: once the fault latches nothing moves until reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         primed_ff <= 1'b0;
         esum_ff   <= '0;
         bad_ff    <= '0;
         fault_ff  <= 1'b0;
      end else if (fire && !fault_ff) begin
         prev_ff   <= prev_in;
         primed_ff <= 1'b1;
         esum_ff   <= esum_in;
         bad_ff    <= bad_in;
         fault_ff  <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff.valid   <= in_valid;
         ctl_ff.standby <= in_standby;
         ctl_ff.fault   <= fault_ff || fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         diff_ff     <= diff_in;
         dtemp_ff    <= dtemp_in;
         esum_out_ff <= esum_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_diff  = diff_ff;
   assign out_dtemp = dtemp_ff;
   assign out_esum  = esum_out_ff;

endmodule

// ===== design/hpid_mult.sv =====
// Product stage: the three Q8.8 gain products, each registered.
`timescale 1ns / 1ps

module hpid_mult #(
   parameter int TEMP_BITS = hpid_pkg::TEMP_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hpid_pkg::stage_ctl_type               in_ctl,
   output logic                                  in_ready,
   input  logic signed [TEMP_BITS:0]             in_diff,
   input  logic signed [TEMP_BITS:0]             in_dtemp,
   input  logic signed [hpid_pkg::ESUM_BITS-1:0] in_esum,
   input  hpid_pkg::cfg_type                     cfg,
   output hpid_pkg::stage_ctl_type               out_ctl,
   output logic signed [TEMP_BITS+17:0]          out_prop,
   output logic signed [hpid_pkg::ESUM_BITS+16:0] out_integ,
   output logic signed [TEMP_BITS+17:0]          out_deriv,
   input  logic                                  out_ready
);

   localparam int PW = TEMP_BITS + 18;
   localparam int IW = hpid_pkg::ESUM_BITS + 17;

   hpid_pkg::stage_ctl_type ctl_ff;
   logic signed [PW-1:0]    prop_ff, deriv_ff, prop_in, deriv_in;
   logic signed [IW-1:0]    integ_ff, integ_in;
   logic [15:0]             gain_p;

   assign in_ready = !ctl_ff.valid || out_ready;

   always_comb begin
      gain_p  = in_ctl.standby ? cfg.gain_prop_standby : cfg.gain_prop;
      prop_in = $signed({1'b0, gain_p}) * in_diff;
      // Standby runs P only, so the other two terms drop out.
      if (in_ctl.standby) begin
         integ_in = '0;
         deriv_in = '0;
      end else begin
         integ_in = $signed({1'b0, cfg.gain_integral}) * in_esum;
         deriv_in = $signed({1'b0, cfg.gain_deriv}) * in_dtemp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         prop_ff  <= prop_in;
         integ_ff <= integ_in;
         deriv_ff <= deriv_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_prop  = prop_ff;
   assign out_integ = integ_ff;
   assign out_deriv = deriv_ff;

endmodule

// ===== design/hpid_out.sv =====
// Result stage: sums the terms, floors to an integer duty and clamps to 0..255; a fault forces duty 0.
`timescale 1ns / 1ps

module hpid_out #(
   parameter int TEMP_BITS = hpid_pkg::TEMP_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  hpid_pkg::stage_ctl_type                in_ctl,
   output logic                                   in_ready,
   input  logic signed [TEMP_BITS+17:0]           in_prop,
   input  logic signed [hpid_pkg::ESUM_BITS+16:0] in_integ,
   input  logic signed [TEMP_BITS+17:0]           in_deriv,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [hpid_pkg::DUTY_BITS-1:0]         rsp_duty,
   output logic                                   rsp_heater_on,
   output logic                                   rsp_fault
);

   localparam int PW = TEMP_BITS + 18;
   localparam int IW = hpid_pkg::ESUM_BITS + 17;
   localparam int AW = ((PW > IW) ? PW : IW) + 2;
   localparam int DW = hpid_pkg::DUTY_BITS;

   logic                 valid_ff, fault_ff;
   logic [DW-1:0]        duty_ff, duty_in;
   logic signed [AW-1:0] acc, low_edge, high_edge;

   assign in_ready  = !valid_ff || rsp_tready;
   assign low_edge  = AW'(1) <<< DW;
   assign high_edge = AW'(hpid_pkg::DUTY_MAX) <<< DW;

   always_comb begin
      acc = AW'(in_prop) + AW'(in_integ) - AW'(in_deriv);
      // Flooring by 256 on a value known to lie in range is just a bit-select.
      if (in_ctl.fault || acc < low_edge) begin
         duty_in = '0;
      end else if (acc >= high_edge) begin
         duty_in = hpid_pkg::DUTY_MAX;
      end else begin
         duty_in = acc[2*DW-1:DW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         duty_ff  <= duty_in;
         fault_ff <= in_ctl.fault;
      end
   end

   assign rsp_tvalid    = valid_ff;
   assign rsp_duty      = duty_ff;
   assign rsp_heater_on = (duty_ff != '0);
   assign rsp_fault     = fault_ff;

endmodule

// ===== design/heater_pid_with_fault_guard_core.sv =====
// Heater PID controller with erratic-sample fault guard: top level.
//
// One request is one control tick; while the result side does not stall, the
// block takes a request in every clock cycle, and it returns one result per
// request, in order. A request passes the input, update, product and result
// registers in that order; a stall on the result side holds it in them. The
// rate of one request per cycle, without stalls, is set by the update stage,
// where the jump check, bad-sample count, fault latch and clamped error sum
// close their loop combinationally into their own registers. Once the fault
// latches every result shows duty 0 and fault 1 until reset. Configuration
// registers are written through the csr channel, which is always ready; they
// should be changed only while no request is in flight.
`timescale 1ns / 1ps

module heater_pid_with_fault_guard_core #(
   parameter int TEMP_BITS = hpid_pkg::TEMP_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // temperature, then target, from bit 0 up; zero padded
   input  logic [((2*TEMP_BITS+7)/8)*8-1:0]    req_tdata,
   // standby
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // duty
   output logic [hpid_pkg::DUTY_BITS-1:0]      rsp_tdata,
   // heater_on, then fault, from bit 0 up
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hpid_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hpid_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int EW = hpid_pkg::ESUM_BITS;

   hpid_pkg::cfg_type cfg_ff;

   logic                 s0_valid_ff, s0_standby_ff;
   logic [TEMP_BITS-1:0] s0_temp_ff, s0_target_ff;
   logic                 upd_ready, mult_ready, out_ready;

   hpid_pkg::stage_ctl_type   upd_ctl, mult_ctl;
   logic signed [TEMP_BITS:0] upd_diff, upd_dtemp;
   logic signed [EW-1:0]      upd_esum;
   logic signed [TEMP_BITS+17:0] mult_prop, mult_deriv;
   logic signed [EW+16:0]     mult_integ;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= hpid_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hpid_pkg::REG_GAIN_PROP:         cfg_ff.gain_prop         <= csr_data;
            hpid_pkg::REG_GAIN_INTEGRAL:     cfg_ff.gain_integral     <= csr_data;
            hpid_pkg::REG_GAIN_DERIV:        cfg_ff.gain_deriv        <= csr_data;
            hpid_pkg::REG_GAIN_PROP_STANDBY: cfg_ff.gain_prop_standby <= csr_data;
            hpid_pkg::REG_STANDBY_TARGET:    cfg_ff.standby_target    <= csr_data[9:0];
            hpid_pkg::REG_INTEGRAL_LIMIT:    cfg_ff.integral_limit    <= csr_data[14:0];
            hpid_pkg::REG_MAX_JUMP:          cfg_ff.max_jump          <= csr_data[9:0];
            hpid_pkg::REG_MAX_BAD_SAMPLES:   cfg_ff.max_bad_samples   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Input register.
   assign req_tready = !s0_valid_ff || upd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s0_temp_ff    <= req_tdata[TEMP_BITS-1:0];
         s0_target_ff  <= req_tdata[2*TEMP_BITS-1:TEMP_BITS];
         s0_standby_ff <= req_tuser;
      end
   end

   hpid_update #(.TEMP_BITS(TEMP_BITS)) u_update (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s0_valid_ff),
      .in_ready   (upd_ready),
      .in_temp    (s0_temp_ff),
      .in_target  (s0_target_ff),
      .in_standby (s0_standby_ff),
      .cfg        (cfg_ff),
      .out_ctl    (upd_ctl),
      .out_diff   (upd_diff),
      .out_dtemp  (upd_dtemp),
      .out_esum   (upd_esum),
      .out_ready  (mult_ready)
   );

   hpid_mult #(.TEMP_BITS(TEMP_BITS)) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (upd_ctl),
      .in_ready  (mult_ready),
      .in_diff   (upd_diff),
      .in_dtemp  (upd_dtemp),
      .in_esum   (upd_esum),
      .cfg       (cfg_ff),
      .out_ctl   (mult_ctl),
      .out_prop  (mult_prop),
      .out_integ (mult_integ),
      .out_deriv (mult_deriv),
      .out_ready (out_ready)
   );

   hpid_out #(.TEMP_BITS(TEMP_BITS)) u_out (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (mult_ctl),
      .in_ready      (out_ready),
      .in_prop       (mult_prop),
      .in_integ      (mult_integ),
      .in_deriv      (mult_deriv),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_duty      (rsp_tdata),
      .rsp_heater_on (rsp_tuser[0]),
      .rsp_fault     (rsp_tuser[1])
   );

endmodule

// ===== design/hpid_checker.sv =====
// Port-level checker for the heater PID controller, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpid_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [hpid_pkg::DUTY_BITS-1:0] rsp_tdata,
   input logic [1:0]                     rsp_tuser
);

   logic seen_fault_ff;

   // Remembers that a faulted result has been delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_fault_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tuser[1]) begin
         seen_fault_ff <= 1'b1;
      end
   end

   `ASSERT_ALWAYS(a_fault_zero_duty, clock, reset, rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0, "faulted result carries nonzero duty")
   `ASSERT_ALWAYS(a_heater_on_match, clock, reset, rsp_tvalid |-> rsp_tuser[0] == (rsp_tdata != '0), "heater_on disagrees with duty")
   `ASSERT_ALWAYS(a_fault_sticky, clock, reset, rsp_tvalid && seen_fault_ff |-> rsp_tuser[1], "fault cleared without reset")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind heater_pid_with_fault_guard_core hpid_checker u_hpid_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the heater PID controller with erratic-sample fault guard.
`timescale 1ns / 1ps

module testbench;

   localparam int TB_TEMP_BITS = hpid_pkg::TEMP_BITS_DEF;
   localparam int REQ_BITS     = ((2*TB_TEMP_BITS+7)/8)*8;
   localparam int PAD_BITS     = REQ_BITS - 2*TB_TEMP_BITS;
   localparam int SETTLE_TICKS = 8;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum {PHASE_MIXED, PHASE_LOW, PHASE_HIGH} phase_kind_type;

   typedef struct packed {
      logic [hpid_pkg::DUTY_BITS-1:0] duty;
      logic                           heater_on;
      logic                           fault;
   } heat_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [REQ_BITS-1:0]                 req_tdata = '0;
   logic                                req_tuser = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [hpid_pkg::DUTY_BITS-1:0]      rsp_tdata;
   logic [1:0]                          rsp_tuser;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [hpid_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [hpid_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;

   // Controller state as the predictor sees it.
   hpid_pkg::cfg_type       heat_cfg = hpid_pkg::CFG_RESET;
   logic [TB_TEMP_BITS-1:0] last_temp = '0;
   int                      esum_model = 0;
   logic [7:0]              bad_run = '0;
   logic                    fault_held = 1'b0;
   logic                    primed_seen = 1'b0;

   heat_result_type expected_duty_q[$];

   int   error_count = 0;
   int   ticks_sent = 0;
   int   results_checked = 0;
   int   reg_writes = 0;
   int   cycle_count = 0;
   int   rsp_hold_left = 0;
   logic idle_bursts_on = 1'b1;

   // Stimulus generator state for the random phases.
   logic [TB_TEMP_BITS-1:0] gen_target = '0;
   logic                    gen_standby = 1'b0;
   int                      burst_left = 0;

   heater_pid_with_fault_guard_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // While idle bursts are on, the result side stalls in bursts of random length.
   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (idle_bursts_on && $urandom_range(0, 4) == 0) begin
         rsp_tready    <= 1'b0;
         rsp_hold_left <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      heat_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_duty_q.size() == 0) begin
            $error("duty: no request waiting, got %0d", rsp_tdata);
            error_count++;
         end else begin
            want = expected_duty_q.pop_front();
            results_checked++;
            if (rsp_tdata !== want.duty) begin
               $error("duty: expected %0d, got %0d", want.duty, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== want.heater_on) begin
               $error("heater_on: expected %0d, got %0d", want.heater_on, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tuser[1] !== want.fault) begin
               $error("fault: expected %0d, got %0d", want.fault, rsp_tuser[1]);
               error_count++;
            end
         end
      end
   end

   function automatic logic [TB_TEMP_BITS-1:0] step_size(input logic [TB_TEMP_BITS-1:0] a,
                                                         input logic [TB_TEMP_BITS-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Advances the controller state by one tick and returns the result it should report.
   function automatic heat_result_type compute_duty(input logic [TB_TEMP_BITS-1:0] temp_in,
                                                    input logic [TB_TEMP_BITS-1:0] target_in,
                                                    input logic standby);
      logic [TB_TEMP_BITS-1:0] temp;
      logic [TB_TEMP_BITS-1:0] goal;
      int                      diff;
      int                      dtemp;
      int                      lim;
      int                      sum;
      longint                  acc;
      heat_result_type         r;
      r    = '0;
      acc  = 0;
      temp = temp_in;
      goal = target_in;
      if (!fault_held) begin
         if (!primed_seen) begin
            last_temp   = temp;
            primed_seen = 1'b1;
         end
         if (step_size(temp, last_temp) > heat_cfg.max_jump) begin
            temp = last_temp;
            if (bad_run != 8'hFF) bad_run++;
            if (bad_run > heat_cfg.max_bad_samples) fault_held = 1'b1;
         end else begin
            bad_run = '0;
         end
         if (standby) goal = heat_cfg.standby_target;
         diff  = int'(goal) - int'(temp);
         dtemp = int'(temp) - int'(last_temp);
         if (standby) begin
            acc = longint'(heat_cfg.gain_prop_standby) * diff;
         end else begin
            lim = int'(heat_cfg.integral_limit);
            sum = esum_model + diff;
            if (sum > lim) sum = lim;
            if (sum < -lim) sum = -lim;
            esum_model = sum;
            acc = longint'(heat_cfg.gain_prop) * diff
                + longint'(heat_cfg.gain_integral) * esum_model
                - longint'(heat_cfg.gain_deriv) * dtemp;
         end
         last_temp = temp;
         if (!fault_held) begin
            if (acc < 256) r.duty = '0;
            else if (acc >= longint'(hpid_pkg::DUTY_MAX) * 256)
               r.duty = hpid_pkg::DUTY_MAX;
            else r.duty = hpid_pkg::DUTY_BITS'(acc / 256);
         end
      end
      r.heater_on = (r.duty != '0);
      r.fault     = fault_held;
      return r;
   endfunction

   task automatic send_tick(input logic [TB_TEMP_BITS-1:0] temp,
                            input logic [TB_TEMP_BITS-1:0] target,
                            input logic standby);
      if (idle_bursts_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_BITS{1'b0}}, target, temp};
      req_tuser  <= standby;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_duty_q.push_back(compute_duty(temp, target, standby));
      ticks_sent++;
   endtask

   // Leaves the request side idle until every result is back and the pipeline is empty.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_duty_q.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input logic [hpid_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [hpid_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         hpid_pkg::REG_GAIN_PROP:         heat_cfg.gain_prop         = value;
         hpid_pkg::REG_GAIN_INTEGRAL:     heat_cfg.gain_integral     = value;
         hpid_pkg::REG_GAIN_DERIV:        heat_cfg.gain_deriv        = value;
         hpid_pkg::REG_GAIN_PROP_STANDBY: heat_cfg.gain_prop_standby = value;
         hpid_pkg::REG_STANDBY_TARGET:    heat_cfg.standby_target    = value[9:0];
         hpid_pkg::REG_INTEGRAL_LIMIT:    heat_cfg.integral_limit    = value[14:0];
         hpid_pkg::REG_MAX_JUMP:          heat_cfg.max_jump          = value[9:0];
         hpid_pkg::REG_MAX_BAD_SAMPLES:   heat_cfg.max_bad_samples   = value[7:0];
         default: ;
      endcase
      reg_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Narrow registers get random upper bits, which the block must discard.
   task automatic load_settings(input hpid_pkg::cfg_type c);
      write_reg(hpid_pkg::REG_GAIN_PROP, c.gain_prop);
      write_reg(hpid_pkg::REG_GAIN_INTEGRAL, c.gain_integral);
      write_reg(hpid_pkg::REG_GAIN_DERIV, c.gain_deriv);
      write_reg(hpid_pkg::REG_GAIN_PROP_STANDBY, c.gain_prop_standby);
      write_reg(hpid_pkg::REG_STANDBY_TARGET, {6'($urandom), c.standby_target});
      write_reg(hpid_pkg::REG_INTEGRAL_LIMIT, {1'($urandom), c.integral_limit});
      write_reg(hpid_pkg::REG_MAX_JUMP, {6'($urandom), c.max_jump});
      write_reg(hpid_pkg::REG_MAX_BAD_SAMPLES, {8'($urandom), c.max_bad_samples});
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(0, 1536));
      endcase
   endfunction

   // Mostly a slow temperature walk, with short runs of erratic samples that stay
   // below the fault threshold.
   task automatic random_tick();
      logic [TB_TEMP_BITS-1:0] temp;
      logic                    want_bad;
      logic                    found;
      int                      lim;
      int                      off;
      int                      t;
      int                      tries;
      if ($urandom_range(0, 24) == 0) gen_target = TB_TEMP_BITS'($urandom);
      if ($urandom_range(0, 29) == 0) gen_standby = ~gen_standby;
      if (burst_left == 0 && $urandom_range(0, 11) == 0) burst_left = $urandom_range(1, 4);
      want_bad = (burst_left != 0) && (bad_run < heat_cfg.max_bad_samples);
      if (burst_left != 0) burst_left--;
      found = 1'b0;
      temp  = last_temp;
      for (tries = 0; tries < 8 && want_bad && !found; tries++) begin
         temp  = TB_TEMP_BITS'($urandom);
         found = step_size(temp, last_temp) > heat_cfg.max_jump;
      end
      if (!found) begin
         lim = int'(heat_cfg.max_jump);
         if (lim > 30 && $urandom_range(0, 3) != 0) lim = 30;
         off = $urandom_range(0, 2*lim);
         t   = int'(last_temp) + off - lim;
         if (t < 0) t = 0;
         if (t > 1023) t = 1023;
         temp = TB_TEMP_BITS'(t);
      end
      if ($urandom_range(0, 39) == 0) begin
         send_tick(temp, TB_TEMP_BITS'($urandom), 1'($urandom));
      end else begin
         send_tick(temp, gen_target, gen_standby);
      end
   endtask

   task automatic test_default_settings();
      send_tick(10'd1023, 10'd0, 1'b0);
      send_tick(10'd1023, 10'd1023, 1'b0);
      send_tick(10'd0, 10'd1023, 1'b0);
      send_tick(10'd1000, 10'd1023, 1'b0);
      send_tick(10'd1000, 10'd0, 1'b1);
      send_tick(10'd980, 10'd1023, 1'b1);
      send_tick(10'd0, 10'd0, 1'b0);
      send_tick(10'd960, 10'd512, 1'b0);
      wait_for_results();
   endtask

   task automatic test_integral_clamp();
      logic [hpid_pkg::CSR_INDEX_BITS-1:0] spare_idx;
      write_reg(hpid_pkg::REG_GAIN_INTEGRAL, 16'd4096);
      write_reg(hpid_pkg::REG_INTEGRAL_LIMIT, 16'd40);
      // An index past the last register must leave every setting alone.
      spare_idx = hpid_pkg::REG_MAX_BAD_SAMPLES
                + hpid_pkg::CSR_INDEX_BITS'($urandom_range(1, 8));
      write_reg(spare_idx, 16'($urandom));
      repeat (3) send_tick(10'd960, 10'd1023, 1'b0);
      repeat (3) send_tick(10'd960, 10'd0, 1'b0);
      send_tick(10'd970, 10'd960, 1'b0);
      wait_for_results();
   endtask

   task automatic test_random_control(input phase_kind_type kind, input int n_ticks);
      hpid_pkg::cfg_type c;
      int                i;
      logic              bursts_at_start;
      bursts_at_start = idle_bursts_on;
      case (kind)
         PHASE_LOW: begin
            c = '0;
            c.gain_prop         = pick_gain();
            c.gain_prop_standby = pick_gain();
         end
         PHASE_HIGH: begin
            c = '1;
         end
         default: begin
            c.gain_prop         = pick_gain();
            c.gain_integral     = pick_gain();
            c.gain_deriv        = pick_gain();
            c.gain_prop_standby = pick_gain();
            c.standby_target    = TB_TEMP_BITS'($urandom);
            c.integral_limit    = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                              : 15'($urandom_range(0, 6000));
            case ($urandom_range(0, 5))
               0:       c.max_jump = '0;
               1:       c.max_jump = '1;
               default: c.max_jump = 10'($urandom_range(5, 80));
            endcase
            c.max_bad_samples = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 12));
         end
      endcase
      load_settings(c);
      for (i = 0; i < n_ticks; i++) begin
         // Stretches without idling, unless the run has already stopped idling.
         if (bursts_at_start && i % 100 == 0) idle_bursts_on = ($urandom_range(0, 3) != 0);
         random_tick();
      end
      wait_for_results();
      idle_bursts_on = bursts_at_start;
   endtask

   task automatic test_bad_count_saturation();
      int i;
      write_reg(hpid_pkg::REG_MAX_JUMP, {6'($urandom), 10'd0});
      write_reg(hpid_pkg::REG_MAX_BAD_SAMPLES, {8'($urandom), 8'd255});
      send_tick(last_temp, TB_TEMP_BITS'($urandom), 1'b0);
      // Any change is erratic here; the count must stop at its ceiling without a fault.
      for (i = 0; i < 262; i++) begin
         send_tick(last_temp ^ TB_TEMP_BITS'($urandom_range(1, 1023)),
                   TB_TEMP_BITS'($urandom), 1'($urandom));
      end
      send_tick(last_temp, TB_TEMP_BITS'($urandom), 1'b0);
      wait_for_results();
      write_reg(hpid_pkg::REG_MAX_JUMP, 16'd40);
      write_reg(hpid_pkg::REG_MAX_BAD_SAMPLES, 16'd6);
   endtask

   task automatic test_fault_latch();
      int i;
      write_reg(hpid_pkg::REG_MAX_JUMP, 16'd5);
      write_reg(hpid_pkg::REG_MAX_BAD_SAMPLES, 16'd2);
      send_tick(last_temp, 10'd1023, 1'b0);
      repeat (3) send_tick(last_temp ^ 10'h200, 10'd1023, 1'b0);
      for (i = 0; i < 6; i++) begin
         send_tick(TB_TEMP_BITS'($urandom), TB_TEMP_BITS'($urandom), 1'($urandom));
      end
      send_tick(last_temp, 10'd1023, 1'b0);
      wait_for_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_settings();
      test_integral_clamp();
      test_random_control(PHASE_MIXED, 280);
      test_random_control(PHASE_LOW, 120);
      test_random_control(PHASE_MIXED, 280);
      test_random_control(PHASE_HIGH, 120);
      test_bad_count_saturation();
      idle_bursts_on = 1'b0;
      test_random_control(PHASE_MIXED, 300);
      test_fault_latch();
      $display("Sent %0d control ticks and %0d register writes; %0d results compared.",
               ticks_sent, reg_writes, results_checked);
      $display("Covered normal and standby modes, integral clamping, erratic runs, %s",
               "bad-count saturation and the fault latch.");
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
